// ===== rtl/acen_pkg.sv =====
// ----------------------------------------------------------------------------
// acen_pkg: shared types and constants of the Anger centroid block
// Field widths, accumulator format, and the control bundles passed between the
// lane, merge and divider stages.
// ----------------------------------------------------------------------------
package acen_pkg;

	// item field widths
	localparam int NUM_CHANS = 8;
	localparam int CHAN_BITS = 16;
	localparam int EN_BITS   = 24;
	localparam int POS_BITS  = 16;

	// accumulators wrap in this two's complement width
	localparam int ACC_BITS  = 27;
	// signed position weights, held in a type that spans -32..31
	localparam int WGT_BITS  = 6;

	// saturation limits, as magnitudes and as codes
	localparam int POS_MAX_MAG = 32767;
	localparam int POS_MIN_MAG = 32768;
	localparam logic signed [POS_BITS-1:0] POS_MAX = 16'sh7FFF;
	localparam logic signed [POS_BITS-1:0] POS_MIN = 16'sh8000;

	typedef logic signed [ACC_BITS-1:0] acc_t;
	typedef logic [EN_BITS-1:0]         energy_t;
	typedef logic signed [WGT_BITS-1:0] wgt_t;
	typedef logic signed [POS_BITS-1:0] pos_t;

	// row control travelling alongside the lane outputs
	typedef struct packed {
		logic    valid;
		logic    last;
		wgt_t    row_w;
		energy_t energy;
	} row_ctl_t;

	// divider result after clipping
	typedef struct packed {
		pos_t pos;
		logic sat;
	} div_res_t;

endpackage

// ===== rtl/acen_if.sv =====
// ----------------------------------------------------------------------------
// acen_if: row and result channels of the Anger centroid block
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface acen_row_if;
	logic                             valid;
	logic                             ready;
	logic [acen_pkg::CHAN_BITS-1:0]   chan_0;
	logic [acen_pkg::CHAN_BITS-1:0]   chan_1;
	logic [acen_pkg::CHAN_BITS-1:0]   chan_2;
	logic [acen_pkg::CHAN_BITS-1:0]   chan_3;
	logic [acen_pkg::CHAN_BITS-1:0]   chan_4;
	logic [acen_pkg::CHAN_BITS-1:0]   chan_5;
	logic [acen_pkg::CHAN_BITS-1:0]   chan_6;
	logic [acen_pkg::CHAN_BITS-1:0]   chan_7;
	logic [acen_pkg::EN_BITS-1:0]     event_energy;

	modport source (
		output valid, chan_0, chan_1, chan_2, chan_3, chan_4, chan_5, chan_6, chan_7,
		       event_energy,
		input  ready
	);
	modport sink (
		input  valid, chan_0, chan_1, chan_2, chan_3, chan_4, chan_5, chan_6, chan_7,
		       event_energy,
		output ready
	);
endinterface

interface acen_res_if;
	logic                                valid;
	logic                                ready;
	logic signed [acen_pkg::POS_BITS-1:0] pos_x;
	logic signed [acen_pkg::POS_BITS-1:0] pos_y;
	logic                                zero_energy;
	logic                                saturated;

	modport source (
		output valid, pos_x, pos_y, zero_energy, saturated,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, zero_energy, saturated,
		output ready
	);
endinterface

// ===== rtl/anger_centroid_8x8.sv =====
// Path: a row is registered in the lanes and then in the merge stage; the last row starts the
// dividers, whose results are clipped and registered at the output. Throughput: one row per
// cycle within an event; the divider takes one quotient bit per cycle, so rows of the next
// event wait from the last row until the result is registered.
// Reset: arst_n clears the row counter, accumulators, divider and output valid at once.
// ----------------------------------------------------------------------------
// anger_centroid_8x8: Anger logic centroid of an 8x8 detector event
// Column lanes weight each row, a merge stage accumulates x and y over the
// event, and two dividers scale by the event energy into clipped positions.
// ----------------------------------------------------------------------------
module anger_centroid_8x8 #(
	parameter int GRID_SIDE   = 8,
	parameter int SAMPLE_BITS = 16,
	parameter int FRAC_BITS   = 12
) (
	input  logic       clk,
	input  logic       arst_n,
	acen_row_if.sink   rows,
	acen_res_if.source centroid
);

	localparam int NLANE = (GRID_SIDE < acen_pkg::NUM_CHANS) ? GRID_SIDE : acen_pkg::NUM_CHANS;
	localparam int SAMPLE_W = (SAMPLE_BITS < acen_pkg::CHAN_BITS) ?
	                          SAMPLE_BITS : acen_pkg::CHAN_BITS;
	localparam int RW = $clog2(GRID_SIDE);

	logic [acen_pkg::CHAN_BITS-1:0] chan [acen_pkg::NUM_CHANS];
	logic                           accept;
	logic                           last;
	logic [RW-1:0]                  row_q;
	logic                           busy_q;
	acen_pkg::wgt_t                 row_w;
	acen_pkg::row_ctl_t             ctl_s1;
	acen_pkg::acc_t                 wx_s1 [NLANE];
	logic [SAMPLE_W-1:0]            e_s1 [NLANE];
	logic                           start;
	acen_pkg::acc_t                 sum_x;
	acen_pkg::acc_t                 sum_y;
	acen_pkg::energy_t              start_energy;
	logic                           zero_q;
	logic                           done_x;
	logic                           done_y;
	acen_pkg::div_res_t             res_x;
	acen_pkg::div_res_t             res_y;
	logic                           out_load;
	logic                           out_valid_q;
	acen_pkg::pos_t                 pos_x_q;
	acen_pkg::pos_t                 pos_y_q;
	logic                           zero_out_q;
	logic                           sat_q;

	// channel fields as an array for the lanes
	always_comb begin
		chan[0] = rows.chan_0;
		chan[1] = rows.chan_1;
		chan[2] = rows.chan_2;
		chan[3] = rows.chan_3;
		chan[4] = rows.chan_4;
		chan[5] = rows.chan_5;
		chan[6] = rows.chan_6;
		chan[7] = rows.chan_7;
	end

	// input handshake and row position
	always_comb begin
		rows.ready = !busy_q;
		accept     = rows.valid && !busy_q;
		last       = row_q == RW'(GRID_SIDE - 1);
		row_w      = acen_pkg::wgt_t'(GRID_SIDE - 1) - acen_pkg::wgt_t'({row_q, 1'b0});
	end

	// row counter and event hold while the divider works
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			busy_q <= 1'b0;
		end else begin
			if (accept) begin
				row_q <= last ? '0 : row_q + RW'(1);
			end
			if (accept && last) begin
				busy_q <= 1'b1;
			end else if (out_load) begin
				busy_q <= 1'b0;
			end
		end
	end

	// row control alongside the lane registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.valid <= accept;
			if (accept) begin
				ctl_s1.last   <= last;
				ctl_s1.row_w  <= row_w;
				ctl_s1.energy <= rows.event_energy;
			end
		end
	end

	// column lanes
	for (genvar c = 0; c < NLANE; c++) begin : g_lane
		acen_lane #(
			.WEIGHT   (GRID_SIDE - 1 - 2 * c),
			.SAMPLE_W (SAMPLE_W)
		) u_lane (
			.clk   (clk),
			.en    (accept),
			.chan  (chan[c]),
			.wx_s1 (wx_s1[c]),
			.e_s1  (e_s1[c])
		);
	end

	// merge and accumulate
	acen_merge #(
		.NLANE    (NLANE),
		.SAMPLE_W (SAMPLE_W)
	) u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_s1 (ctl_s1),
		.wx_s1  (wx_s1),
		.e_s1   (e_s1),
		.start  (start),
		.sum_x  (sum_x),
		.sum_y  (sum_y),
		.energy (start_energy)
	);

	// x and y dividers run together
	acen_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.ack    (out_load),
		.acc    (sum_x),
		.energy (start_energy),
		.done   (done_x),
		.res    (res_x)
	);

	acen_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.ack    (out_load),
		.acc    (sum_y),
		.energy (start_energy),
		.done   (done_y),
		.res    (res_y)
	);

	// zero energy flag taken when the event enters the dividers
	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= start_energy == '0;
		end
	end

	assign out_load = done_x && done_y && (!out_valid_q || centroid.ready);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (centroid.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pos_x_q    <= zero_q ? '0 : res_x.pos;
			pos_y_q    <= zero_q ? '0 : res_y.pos;
			zero_out_q <= zero_q;
			sat_q      <= !zero_q && (res_x.sat || res_y.sat);
		end
	end

	// result channel
	always_comb begin
		centroid.valid       = out_valid_q;
		centroid.pos_x       = pos_x_q;
		centroid.pos_y       = pos_y_q;
		centroid.zero_energy = zero_out_q;
		centroid.saturated   = sat_q;
	end

endmodule

// ===== rtl/acen_lane.sv =====
// ----------------------------------------------------------------------------
// acen_lane: one column lane
// Masks the channel sample and registers it with its column-weighted value.
// ----------------------------------------------------------------------------
module acen_lane #(
	parameter int WEIGHT   = 7,
	parameter int SAMPLE_W = 16
) (
	input  logic                           clk,
	input  logic                           en,
	input  logic [acen_pkg::CHAN_BITS-1:0] chan,
	output acen_pkg::acc_t                 wx_s1,
	output logic [SAMPLE_W-1:0]            e_s1
);

	localparam acen_pkg::wgt_t W = acen_pkg::wgt_t'(WEIGHT);

	logic [SAMPLE_W-1:0] e;
	acen_pkg::acc_t      e_ext;
	acen_pkg::acc_t      w_ext;

	// keep only the sample bits, widen for the weight product
	always_comb begin
		e     = chan[SAMPLE_W-1:0];
		e_ext = acen_pkg::acc_t'(e);
		w_ext = acen_pkg::acc_t'(W);
	end

	// lane register
	always_ff @(posedge clk) begin
		if (en) begin
			wx_s1 <= e_ext * w_ext;
			e_s1  <= e;
		end
	end

endmodule

// ===== rtl/acen_merge.sv =====
// ----------------------------------------------------------------------------
// acen_merge: lane merge and event accumulators
// Sums the lane outputs, applies the row weight, and accumulates x and y over
// the rows of one event; flags the last row towards the divider.
// ----------------------------------------------------------------------------
module acen_merge #(
	parameter int NLANE    = 8,
	parameter int SAMPLE_W = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  acen_pkg::row_ctl_t  ctl_s1,
	input  acen_pkg::acc_t      wx_s1 [NLANE],
	input  logic [SAMPLE_W-1:0] e_s1 [NLANE],
	output logic                start,
	output acen_pkg::acc_t      sum_x,
	output acen_pkg::acc_t      sum_y,
	output acen_pkg::energy_t   energy
);

	localparam int RSW = SAMPLE_W + 4;

	acen_pkg::acc_t     xs;
	logic [RSW-1:0]     rs;
	acen_pkg::acc_t     rs_ext;
	acen_pkg::acc_t     rw_ext;
	acen_pkg::acc_t     xs_s2;
	acen_pkg::acc_t     ys_s2;
	acen_pkg::row_ctl_t ctl_s2;
	acen_pkg::acc_t     acc_x_q;
	acen_pkg::acc_t     acc_y_q;

	// sum over the lanes
	always_comb begin
		xs = '0;
		rs = '0;
		for (int i = 0; i < NLANE; i++) begin
			xs = xs + wx_s1[i];
			rs = rs + RSW'(e_s1[i]);
		end
		rs_ext = acen_pkg::acc_t'(rs);
		rw_ext = acen_pkg::acc_t'(ctl_s1.row_w);
	end

	// merged row terms
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			xs_s2  <= '0;
			ys_s2  <= '0;
		end else begin
			ctl_s2 <= ctl_s1;
			if (ctl_s1.valid) begin
				xs_s2 <= xs;
				ys_s2 <= rs_ext * rw_ext;
			end
		end
	end

	// running sums including the row now in stage two
	always_comb begin
		sum_x  = acc_x_q + xs_s2;
		sum_y  = acc_y_q + ys_s2;
		start  = ctl_s2.valid && ctl_s2.last;
		energy = ctl_s2.energy;
	end

	// event accumulators, cleared once the last row has gone to the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_x_q <= '0;
			acc_y_q <= '0;
		end else if (ctl_s2.valid) begin
			if (ctl_s2.last) begin
				acc_x_q <= '0;
				acc_y_q <= '0;
			end else begin
				acc_x_q <= sum_x;
				acc_y_q <= sum_y;
			end
		end
	end

endmodule

// ===== rtl/acen_div.sv =====
// ----------------------------------------------------------------------------
// acen_div: sequential centroid divider
// Restoring division of the scaled accumulator magnitude by the event energy,
// one quotient bit per cycle, then sign and clipping to the position range.
// ----------------------------------------------------------------------------
module acen_div #(
	parameter int FRAC_BITS = 12
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                ack,
	input  acen_pkg::acc_t      acc,
	input  acen_pkg::energy_t   energy,
	output logic                done,
	output acen_pkg::div_res_t  res
);

	localparam int DW = acen_pkg::ACC_BITS + FRAC_BITS;
	localparam int CW = $clog2(DW + 1);
	localparam int EB = acen_pkg::EN_BITS;

	typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

	state_t                        state_q;
	logic [DW-1:0]                 quo_q;
	logic [EB-1:0]                 rem_q;
	logic [EB-1:0]                 den_q;
	logic                          neg_q;
	logic [CW-1:0]                 cnt_q;
	logic [acen_pkg::ACC_BITS-1:0] mag;
	logic [EB:0]                   trial;
	logic [EB:0]                   diff;
	logic                          fits;

	// magnitude and one restoring step
	always_comb begin
		mag   = acc[acen_pkg::ACC_BITS-1] ? acen_pkg::ACC_BITS'(-acc) : acc;
		trial = {rem_q, quo_q[DW-1]};
		fits  = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			quo_q   <= '0;
			rem_q   <= '0;
			den_q   <= '0;
			neg_q   <= 1'b0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						quo_q   <= {mag, {FRAC_BITS{1'b0}}};
						rem_q   <= '0;
						den_q   <= energy;
						neg_q   <= acc[acen_pkg::ACC_BITS-1];
						cnt_q   <= CW'(DW);
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					quo_q <= {quo_q[DW-2:0], fits};
					rem_q <= fits ? diff[EB-1:0] : trial[EB-1:0];
					cnt_q <= cnt_q - CW'(1);
					if (cnt_q == CW'(1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (ack) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// sign and clip the quotient
	always_comb begin
		done    = state_q == ST_DONE;
		res.sat = 1'b0;
		if (neg_q) begin
			if (quo_q > DW'(acen_pkg::POS_MIN_MAG)) begin
				res.pos = acen_pkg::POS_MIN;
				res.sat = 1'b1;
			end else begin
				res.pos = acen_pkg::pos_t'(-quo_q[acen_pkg::POS_BITS-1:0]);
			end
		end else begin
			if (quo_q > DW'(acen_pkg::POS_MAX_MAG)) begin
				res.pos = acen_pkg::POS_MAX;
				res.sat = 1'b1;
			end else begin
				res.pos = acen_pkg::pos_t'(quo_q[acen_pkg::POS_BITS-1:0]);
			end
		end
	end

endmodule
